// ===== sv/cbl_pkg.sv =====
// ----------------------------------------------------------------------------
// cbl_pkg
// Shared types and constants of the checksummed block loader: phase and
// command codes, result kinds, register map and queue sizing.
// ----------------------------------------------------------------------------
package cbl_pkg;

    // default sizing of the block
    localparam int BUFFER_BYTES_DEF = 64;
    localparam int ADDRESS_BITS_DEF = 24;

    // fixed field widths
    localparam int BYTE_W  = 8;
    localparam int BASE_W  = 24;
    localparam int KIND_W  = 2;

    // configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // session phase of the front
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LENGTH,
        PH_DATA
    } phase_t;

    // work handed from front to back
    typedef enum logic [1:0] {
        OP_ACK,
        OP_NACK,
        OP_END,
        OP_DRAIN
    } cmd_op_t;

    // result kinds on the output channel
    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_NACK  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_END   = 2'd3
    } kind_t;

    // back sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_WRITE,
        BK_REPLY
    } back_state_t;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_START = 3'd0,
        REG_END   = 3'd1,
        REG_ACK   = 3'd2,
        REG_NACK  = 3'd3,
        REG_BASE  = 3'd4
    } reg_index_t;

    // status seen by the front
    typedef struct packed {
        logic full;
        logic drain_pending;
    } queue_status_t;

endpackage

// ===== sv/checksummed_block_loader.sv =====
// ----------------------------------------------------------------------------
// checksummed_block_loader
// Serial image loader: start/length/data session protocol with an 8-bit block
// checksum, emitting reply items and buffered memory writes.
//
//   channel  signals                                         direction
//   input    in_valid, in_stall, rx_byte                     in
//   output   out_valid, out_stall, kind, reply_byte,         out
//            write_address, write_data, last
//   config   psel, penable, pwrite, paddr, pwdata, prdata,   in/out
//            pready
//
// The front takes one byte per cycle while the command queue has room; a
// data byte waits while an earlier block is still being drained. The back
// emits each reply through its output register and each memory write by
// a buffer read, then the output register. Reset is asynchronous; the block
// buffer is not cleared. A stalled output holds its item while the front
// keeps taking bytes as far as its own stall conditions allow.
// ----------------------------------------------------------------------------
module checksummed_block_loader #(
    parameter int BUFFER_BYTES = cbl_pkg::BUFFER_BYTES_DEF,
    parameter int ADDRESS_BITS = cbl_pkg::ADDRESS_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [cbl_pkg::BYTE_W-1:0]     rx_byte,
    // output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [cbl_pkg::KIND_W-1:0]     kind,
    output logic [cbl_pkg::BYTE_W-1:0]     reply_byte,
    output logic [cbl_pkg::BASE_W-1:0]     write_address,
    output logic [cbl_pkg::BYTE_W-1:0]     write_data,
    output logic                           last,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cbl_pkg::PADDR_W-1:0]    paddr,
    input  logic [cbl_pkg::PDATA_W-1:0]    pwdata,
    output logic [cbl_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);

    localparam int IDX_W  = $clog2(BUFFER_BYTES);
    localparam int CNT_W  = $clog2(BUFFER_BYTES + 1);
    localparam int OP_W   = $bits(cbl_pkg::cmd_op_t);
    localparam int CMD_W  = OP_W + CNT_W + ADDRESS_BITS;

    logic [cbl_pkg::BYTE_W-1:0]    start_code_reg;
    logic [cbl_pkg::BYTE_W-1:0]    end_code_reg;
    logic [cbl_pkg::BYTE_W-1:0]    ack_code_reg;
    logic [cbl_pkg::BYTE_W-1:0]    nack_code_reg;
    logic [cbl_pkg::BASE_W-1:0]    image_base_address_reg;

    cbl_pkg::reg_index_t           reg_idx;
    logic                          cfg_write;

    cbl_pkg::queue_status_t        q_status;
    logic                          cmd_push;
    cbl_pkg::cmd_op_t              cmd_op_in;
    logic [CNT_W-1:0]              cmd_cnt_in;
    logic [ADDRESS_BITS-1:0]       cmd_addr_in;
    logic [CMD_W-1:0]              q_push_data;
    logic [CMD_W-1:0]              q_pop_data;
    logic                          q_pop;
    logic                          q_empty;
    logic                          q_full;
    logic                          back_busy;

    logic                          buf_wr_en;
    logic [IDX_W-1:0]              buf_wr_idx;
    logic [cbl_pkg::BYTE_W-1:0]    buf_wr_data;

    // register access
    assign pready    = 1'b1;
    assign reg_idx   = cbl_pkg::reg_index_t'(paddr[cbl_pkg::PADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg         <= '0;
            end_code_reg           <= '0;
            ack_code_reg           <= '0;
            nack_code_reg          <= '0;
            image_base_address_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                cbl_pkg::REG_START: start_code_reg <= pwdata[cbl_pkg::BYTE_W-1:0];
                cbl_pkg::REG_END:   end_code_reg   <= pwdata[cbl_pkg::BYTE_W-1:0];
                cbl_pkg::REG_ACK:   ack_code_reg   <= pwdata[cbl_pkg::BYTE_W-1:0];
                cbl_pkg::REG_NACK:  nack_code_reg  <= pwdata[cbl_pkg::BYTE_W-1:0];
                cbl_pkg::REG_BASE:
                    image_base_address_reg <= pwdata[cbl_pkg::BASE_W-1:0];
                default:
                    start_code_reg <= start_code_reg;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (reg_idx)
            cbl_pkg::REG_START: prdata = cbl_pkg::PDATA_W'(start_code_reg);
            cbl_pkg::REG_END:   prdata = cbl_pkg::PDATA_W'(end_code_reg);
            cbl_pkg::REG_ACK:   prdata = cbl_pkg::PDATA_W'(ack_code_reg);
            cbl_pkg::REG_NACK:  prdata = cbl_pkg::PDATA_W'(nack_code_reg);
            cbl_pkg::REG_BASE:  prdata = cbl_pkg::PDATA_W'(image_base_address_reg);
            default:            prdata = '0;
        endcase
    end

    // queue status toward the front
    assign q_status.full          = q_full;
    assign q_status.drain_pending = !q_empty || back_busy;

    cbl_front #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .rx_byte            (rx_byte),
        .start_code         (start_code_reg),
        .end_code           (end_code_reg),
        .image_base_address (image_base_address_reg),
        .q_status           (q_status),
        .cmd_push           (cmd_push),
        .cmd_op             (cmd_op_in),
        .cmd_cnt            (cmd_cnt_in),
        .cmd_addr           (cmd_addr_in),
        .buf_wr_en          (buf_wr_en),
        .buf_wr_idx         (buf_wr_idx),
        .buf_wr_data        (buf_wr_data)
    );

    assign q_push_data = {cmd_op_in, cmd_cnt_in, cmd_addr_in};

    cbl_queue #(
        .DATA_W (CMD_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    cbl_back #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .buf_wr_en     (buf_wr_en),
        .buf_wr_idx    (buf_wr_idx),
        .buf_wr_data   (buf_wr_data),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .cmd_op        (cbl_pkg::cmd_op_t'(q_pop_data[CMD_W-1 -: OP_W])),
        .cmd_cnt       (q_pop_data[ADDRESS_BITS +: CNT_W]),
        .cmd_addr      (q_pop_data[ADDRESS_BITS-1:0]),
        .busy          (back_busy),
        .ack_code      (ack_code_reg),
        .nack_code     (nack_code_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .reply_byte    (reply_byte),
        .write_address (write_address),
        .write_data    (write_data),
        .last          (last)
    );

endmodule

// ===== sv/cbl_front.sv =====
// ----------------------------------------------------------------------------
// cbl_front
// Session protocol: classifies received bytes, keeps length, count, sum and
// write address, fills the block buffer and issues commands to the back.
// ----------------------------------------------------------------------------
module cbl_front #(
    parameter int BUFFER_BYTES = cbl_pkg::BUFFER_BYTES_DEF,
    parameter int ADDRESS_BITS = cbl_pkg::ADDRESS_BITS_DEF,
    parameter int IDX_W        = $clog2(BUFFER_BYTES),
    parameter int CNT_W        = $clog2(BUFFER_BYTES + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [cbl_pkg::BYTE_W-1:0]    rx_byte,
    // configuration
    input  logic [cbl_pkg::BYTE_W-1:0]    start_code,
    input  logic [cbl_pkg::BYTE_W-1:0]    end_code,
    input  logic [cbl_pkg::BASE_W-1:0]    image_base_address,
    // queue side
    input  cbl_pkg::queue_status_t        q_status,
    output logic                          cmd_push,
    output cbl_pkg::cmd_op_t              cmd_op,
    output logic [CNT_W-1:0]              cmd_cnt,
    output logic [ADDRESS_BITS-1:0]       cmd_addr,
    // buffer write port
    output logic                          buf_wr_en,
    output logic [IDX_W-1:0]              buf_wr_idx,
    output logic [cbl_pkg::BYTE_W-1:0]    buf_wr_data
);

    cbl_pkg::phase_t               phase_reg, phase_next;
    logic [cbl_pkg::BYTE_W-1:0]    expected_length_reg, expected_length_next;
    logic [CNT_W-1:0]              received_count_reg, received_count_next;
    logic [cbl_pkg::BYTE_W-1:0]    running_sum_reg, running_sum_next;
    logic [ADDRESS_BITS-1:0]       next_address_reg, next_address_next;

    logic                          take;
    logic                          is_end;
    logic                          is_start;
    logic [cbl_pkg::BYTE_W-1:0]    len;
    logic                          too_long;
    logic [CNT_W-1:0]              count_inc;
    logic [cbl_pkg::BYTE_W-1:0]    sum_new;
    logic                          blk_done;
    logic                          sum_ok;
    logic [ADDRESS_BITS-1:0]       base_a;

    // all bytes wait while the command queue is full; data bytes also wait while the buffer is still being drained
    assign in_stall = q_status.full ||
                      ((phase_reg == cbl_pkg::PH_DATA) && q_status.drain_pending);
    assign take     = in_valid && !in_stall;

    // byte classification
    assign is_end    = (rx_byte == end_code);
    assign is_start  = (rx_byte == start_code);
    assign len       = (rx_byte == '0) ? cbl_pkg::BYTE_W'(1) : rx_byte;
    assign too_long  = {1'b0, len} > 9'(BUFFER_BYTES);
    assign count_inc = received_count_reg + CNT_W'(1);
    assign sum_new   = running_sum_reg + rx_byte;
    assign blk_done  = 9'(count_inc) >= {1'b0, expected_length_reg};
    assign sum_ok    = (~sum_new) == '0;
    assign base_a    = ADDRESS_BITS'(image_base_address);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            unique case (phase_reg)
                cbl_pkg::PH_LENGTH:
                begin
                    if (is_end || too_long)
                        phase_next = cbl_pkg::PH_IDLE;
                    else
                        phase_next = cbl_pkg::PH_DATA;
                end
                cbl_pkg::PH_DATA:
                begin
                    if (blk_done)
                        phase_next = sum_ok ? cbl_pkg::PH_LENGTH : cbl_pkg::PH_IDLE;
                end
                default:
                begin
                    if (is_start)
                        phase_next = cbl_pkg::PH_LENGTH;
                end
            endcase
        end
    end

    // commands, buffer writes and session counters
    always_comb
    begin
        cmd_push             = 1'b0;
        cmd_op               = cbl_pkg::OP_ACK;
        cmd_cnt              = received_count_reg;
        cmd_addr             = next_address_reg;
        buf_wr_en            = 1'b0;
        buf_wr_idx           = received_count_reg[IDX_W-1:0];
        buf_wr_data          = rx_byte;
        expected_length_next = expected_length_reg;
        received_count_next  = received_count_reg;
        running_sum_next     = running_sum_reg;
        next_address_next    = next_address_reg;
        if (take)
        begin
            unique case (phase_reg)
                cbl_pkg::PH_LENGTH:
                begin
                    if (is_end)
                    begin
                        cmd_push = 1'b1;
                        cmd_op   = cbl_pkg::OP_END;
                    end
                    else if (too_long)
                    begin
                        cmd_push          = 1'b1;
                        cmd_op            = cbl_pkg::OP_NACK;
                        next_address_next = base_a;
                    end
                    else
                    begin
                        expected_length_next = len;
                        received_count_next  = '0;
                        running_sum_next     = '0;
                    end
                end
                cbl_pkg::PH_DATA:
                begin
                    buf_wr_en           = 1'b1;
                    received_count_next = count_inc;
                    running_sum_next    = sum_new;
                    if (blk_done)
                    begin
                        cmd_push            = 1'b1;
                        received_count_next = '0;
                        running_sum_next    = '0;
                        if (sum_ok)
                        begin
                            // all bytes but the checksum go to memory
                            cmd_op            = cbl_pkg::OP_DRAIN;
                            next_address_next = next_address_reg +
                                                ADDRESS_BITS'(received_count_reg);
                        end
                        else
                        begin
                            cmd_op            = cbl_pkg::OP_NACK;
                            next_address_next = base_a;
                        end
                    end
                end
                default:
                begin
                    if (is_start)
                    begin
                        cmd_push          = 1'b1;
                        cmd_op            = cbl_pkg::OP_ACK;
                        next_address_next = base_a;
                    end
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= cbl_pkg::PH_IDLE;
            expected_length_reg <= '0;
            received_count_reg  <= '0;
            running_sum_reg     <= '0;
            next_address_reg    <= '0;
        end
        else
        begin
            phase_reg           <= phase_next;
            expected_length_reg <= expected_length_next;
            received_count_reg  <= received_count_next;
            running_sum_reg     <= running_sum_next;
            next_address_reg    <= next_address_next;
        end
    end

endmodule

// ===== sv/cbl_queue.sv =====
// ----------------------------------------------------------------------------
// cbl_queue
// Short command queue that decouples the protocol front from the result
// back end.
// ----------------------------------------------------------------------------
module cbl_queue #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty,
    output logic              full
);

    localparam int PTR_W = (cbl_pkg::QUEUE_DEPTH > 1) ? $clog2(cbl_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(cbl_pkg::QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [cbl_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(cbl_pkg::QUEUE_DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // pointer and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(cbl_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(cbl_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== sv/cbl_back.sv =====
// ----------------------------------------------------------------------------
// cbl_back
// Carries out queued commands: owns the block buffer, drains a passing block
// as memory writes and emits reply and end items through an output register.
// ----------------------------------------------------------------------------
module cbl_back #(
    parameter int BUFFER_BYTES = cbl_pkg::BUFFER_BYTES_DEF,
    parameter int ADDRESS_BITS = cbl_pkg::ADDRESS_BITS_DEF,
    parameter int IDX_W        = $clog2(BUFFER_BYTES),
    parameter int CNT_W        = $clog2(BUFFER_BYTES + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // buffer write port from the front
    input  logic                          buf_wr_en,
    input  logic [IDX_W-1:0]              buf_wr_idx,
    input  logic [cbl_pkg::BYTE_W-1:0]    buf_wr_data,
    // queue side
    input  logic                          q_empty,
    output logic                          q_pop,
    input  cbl_pkg::cmd_op_t              cmd_op,
    input  logic [CNT_W-1:0]              cmd_cnt,
    input  logic [ADDRESS_BITS-1:0]       cmd_addr,
    output logic                          busy,
    // configuration
    input  logic [cbl_pkg::BYTE_W-1:0]    ack_code,
    input  logic [cbl_pkg::BYTE_W-1:0]    nack_code,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cbl_pkg::KIND_W-1:0]    kind,
    output logic [cbl_pkg::BYTE_W-1:0]    reply_byte,
    output logic [cbl_pkg::BASE_W-1:0]    write_address,
    output logic [cbl_pkg::BYTE_W-1:0]    write_data,
    output logic                          last
);

    logic [cbl_pkg::BYTE_W-1:0]    mem [BUFFER_BYTES];
    logic [cbl_pkg::BYTE_W-1:0]    rd_data_reg;

    cbl_pkg::back_state_t          state_reg, state_next;
    cbl_pkg::cmd_op_t              op_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              idx_reg;
    logic [ADDRESS_BITS-1:0]       addr_reg;
    logic [CNT_W-1:0]              idx_inc;

    logic                          out_valid_reg;
    cbl_pkg::kind_t                kind_reg, kind_next;
    logic [cbl_pkg::BYTE_W-1:0]    reply_byte_reg, reply_byte_next;
    logic [cbl_pkg::BASE_W-1:0]    write_address_reg, write_address_next;
    logic [cbl_pkg::BYTE_W-1:0]    write_data_reg, write_data_next;
    logic                          last_reg, last_next;

    logic                          slot_free;
    logic                          rd_en;
    logic                          load_out;

    assign slot_free = !out_valid_reg || !out_stall;
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign busy      = (state_reg != cbl_pkg::BK_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cbl_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    if ((cmd_op == cbl_pkg::OP_DRAIN) && (cmd_cnt != '0))
                        state_next = cbl_pkg::BK_READ;
                    else
                        state_next = cbl_pkg::BK_REPLY;
                end
            end
            cbl_pkg::BK_READ:
                state_next = cbl_pkg::BK_WRITE;
            cbl_pkg::BK_WRITE:
            begin
                if (slot_free)
                    state_next = (idx_inc == cnt_reg) ? cbl_pkg::BK_REPLY : cbl_pkg::BK_READ;
            end
            cbl_pkg::BK_REPLY:
            begin
                if (slot_free)
                    state_next = cbl_pkg::BK_IDLE;
            end
            default:
                state_next = cbl_pkg::BK_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        q_pop              = 1'b0;
        rd_en              = 1'b0;
        load_out           = 1'b0;
        kind_next          = cbl_pkg::KIND_ACK;
        reply_byte_next    = '0;
        write_address_next = '0;
        write_data_next    = '0;
        last_next          = 1'b0;
        unique case (state_reg)
            cbl_pkg::BK_IDLE:
                q_pop = !q_empty;
            cbl_pkg::BK_READ:
                rd_en = 1'b1;
            cbl_pkg::BK_WRITE:
            begin
                load_out           = slot_free;
                kind_next          = cbl_pkg::KIND_WRITE;
                write_address_next = cbl_pkg::BASE_W'(addr_reg);
                write_data_next    = rd_data_reg;
            end
            cbl_pkg::BK_REPLY:
            begin
                load_out  = slot_free;
                last_next = 1'b1;
                case (op_reg)
                    cbl_pkg::OP_NACK:
                    begin
                        kind_next       = cbl_pkg::KIND_NACK;
                        reply_byte_next = nack_code;
                    end
                    cbl_pkg::OP_END:
                        kind_next = cbl_pkg::KIND_END;
                    default:
                    begin
                        kind_next       = cbl_pkg::KIND_ACK;
                        reply_byte_next = ack_code;
                    end
                endcase
            end
            default:
                q_pop = 1'b0;
        endcase
    end

    // sequencer state and output valid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cbl_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // command and output payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg   <= cmd_op;
            cnt_reg  <= cmd_cnt;
            addr_reg <= cmd_addr;
            idx_reg  <= '0;
        end
        else if (load_out && (state_reg == cbl_pkg::BK_WRITE))
        begin
            idx_reg  <= idx_inc;
            addr_reg <= addr_reg + ADDRESS_BITS'(1);
        end
        if (load_out)
        begin
            kind_reg          <= kind_next;
            reply_byte_reg    <= reply_byte_next;
            write_address_reg <= write_address_next;
            write_data_reg    <= write_data_next;
            last_reg          <= last_next;
        end
    end

    // block buffer
    always_ff @(posedge clk)
    begin
        if (buf_wr_en)
            mem[buf_wr_idx] <= buf_wr_data;
        if (rd_en)
            rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign reply_byte    = reply_byte_reg;
    assign write_address = write_address_reg;
    assign write_data    = write_data_reg;
    assign last          = last_reg;

endmodule

// ===== tb/checksummed_block_loader_test.sv =====
// ----------------------------------------------------------------------------
// checksummed_block_loader_test
// Drives received bytes through the loader session protocol (start code,
// block lengths, data with checksum, end code) under several register
// settings, predicts every reply, memory write and end-of-image item, and
// compares each output item field by field in arrival order.
// ----------------------------------------------------------------------------
module checksummed_block_loader_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int BUFFER_BYTES  = cbl_pkg::BUFFER_BYTES_DEF;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int BYTE_W        = cbl_pkg::BYTE_W;
    localparam int BASE_W        = cbl_pkg::BASE_W;
    localparam int KIND_W        = cbl_pkg::KIND_W;
    localparam int PADDR_W       = cbl_pkg::PADDR_W;
    localparam int PDATA_W       = cbl_pkg::PDATA_W;

    // one output item of the loader
    typedef struct packed {
        cbl_pkg::kind_t    kind;
        logic [BYTE_W-1:0] reply;
        logic [BASE_W-1:0] addr;
        logic [BYTE_W-1:0] data;
        logic              last;
    } loader_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [BYTE_W-1:0]   rx_byte;
    logic                out_valid;
    logic                out_stall;
    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   reply_byte;
    logic [BASE_W-1:0]   write_address;
    logic [BYTE_W-1:0]   write_data;
    logic                last;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // register copies used for prediction
    logic [BYTE_W-1:0]   cfg_start;
    logic [BYTE_W-1:0]   cfg_end;
    logic [BYTE_W-1:0]   cfg_ack;
    logic [BYTE_W-1:0]   cfg_nack;
    logic [BASE_W-1:0]   cfg_base;

    // loader state as predicted
    cbl_pkg::phase_t     model_phase;
    int                  model_len;
    int                  model_count;
    logic [BYTE_W-1:0]   model_sum;
    logic [BASE_W-1:0]   model_next_addr;
    logic [BYTE_W-1:0]   model_block [BUFFER_BYTES];

    loader_result_t      loader_results_due [$];
    loader_result_t      head;
    int                  errors;
    int                  sent_items;
    int                  cycle_count;
    logic                quiet;

    checksummed_block_loader u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .reply_byte    (reply_byte),
        .write_address (write_address),
        .write_data    (write_data),
        .last          (last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    always #(CLK_PERIOD / 2) clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // random receiver stall, off during quiet stretches
    always @(posedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(99) < 15);
    end

    task automatic note_error(input string label, input logic [BASE_W-1:0] want,
                              input logic [BASE_W-1:0] got);
    begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, label, want, got);
    end
    endtask

    task automatic check_field(input string label, input logic [BASE_W-1:0] want,
                               input logic [BASE_W-1:0] got);
    begin
        if (want !== got)
            note_error(label, want, got);
    end
    endtask

    // compare each output item with the oldest predicted one
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (loader_results_due.size() == 0)
                note_error("unexpected item kind", '0, BASE_W'(kind));
            else
            begin
                head = loader_results_due.pop_front();
                check_field("kind", BASE_W'(head.kind), BASE_W'(kind));
                check_field("reply_byte", BASE_W'(head.reply), BASE_W'(reply_byte));
                check_field("write_address", head.addr, write_address);
                check_field("write_data", BASE_W'(head.data), BASE_W'(write_data));
                check_field("last", BASE_W'(head.last), BASE_W'(last));
            end
        end
    end

    task automatic push_result(input cbl_pkg::kind_t k, input logic [BYTE_W-1:0] r,
                               input logic [BASE_W-1:0] a, input logic [BYTE_W-1:0] d,
                               input logic l);
        loader_result_t item;
    begin
        item.kind  = k;
        item.reply = r;
        item.addr  = a;
        item.data  = d;
        item.last  = l;
        loader_results_due.push_back(item);
    end
    endtask

    // advance the predicted session by one received byte
    task automatic compute_loader_results(input logic [BYTE_W-1:0] b);
        int eff_len;
        int n_writes;
        int i;
    begin
        case (model_phase)
            cbl_pkg::PH_LENGTH:
            begin
                if (b == cfg_end)
                begin
                    push_result(cbl_pkg::KIND_END, '0, '0, '0, 1'b1);
                    model_phase = cbl_pkg::PH_IDLE;
                end
                else
                begin
                    // zero length counts as a lone checksum byte
                    eff_len = (b == '0) ? 1 : int'(b);
                    if (eff_len > BUFFER_BYTES)
                    begin
                        model_next_addr = cfg_base;
                        push_result(cbl_pkg::KIND_NACK, cfg_nack, '0, '0, 1'b1);
                        model_phase = cbl_pkg::PH_IDLE;
                    end
                    else
                    begin
                        model_len   = eff_len;
                        model_count = 0;
                        model_sum   = '0;
                        model_phase = cbl_pkg::PH_DATA;
                    end
                end
            end
            cbl_pkg::PH_DATA:
            begin
                if (model_count < BUFFER_BYTES)
                    model_block[model_count] = b;
                model_count++;
                model_sum = model_sum + b;
                if (model_count >= model_len)
                begin
                    if (model_sum != 8'hFF)
                    begin
                        model_next_addr = cfg_base;
                        push_result(cbl_pkg::KIND_NACK, cfg_nack, '0, '0, 1'b1);
                        model_phase = cbl_pkg::PH_IDLE;
                    end
                    else
                    begin
                        // all but the checksum byte go to memory
                        n_writes = model_count - 1;
                        if (n_writes > BUFFER_BYTES - 1)
                            n_writes = BUFFER_BYTES - 1;
                        for (i = 0; i < n_writes; i++)
                            push_result(cbl_pkg::KIND_WRITE, '0,
                                        model_next_addr + BASE_W'(i),
                                        model_block[i], 1'b0);
                        model_next_addr = model_next_addr + BASE_W'(n_writes);
                        push_result(cbl_pkg::KIND_ACK, cfg_ack, '0, '0, 1'b1);
                        model_phase = cbl_pkg::PH_LENGTH;
                    end
                    model_count = 0;
                    model_sum   = '0;
                end
            end
            default:
            begin
                if (b == cfg_start)
                begin
                    model_next_addr = cfg_base;
                    push_result(cbl_pkg::KIND_ACK, cfg_ack, '0, '0, 1'b1);
                    model_phase = cbl_pkg::PH_LENGTH;
                end
            end
        endcase
    end
    endtask

    // send one item, with a random gap first unless quiet
    task automatic send_byte(input logic [BYTE_W-1:0] b);
    begin
        if (!quiet && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        compute_loader_results(b);
        sent_items++;
    end
    endtask

    // hold the sender until every predicted item has come out
    task automatic wait_drained();
    begin
        in_valid <= 1'b0;
        while (loader_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    end
    endtask

    // bring the predicted session back to idle
    task automatic close_session();
    begin
        while (model_phase != cbl_pkg::PH_IDLE)
        begin
            if (model_phase == cbl_pkg::PH_LENGTH)
                send_byte(cfg_end);
            else
                send_byte(BYTE_W'($urandom_range(255)));
        end
    end
    endtask

    task automatic write_reg(input cbl_pkg::reg_index_t idx,
                             input logic [PDATA_W-1:0] value);
    begin
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            cbl_pkg::REG_START: cfg_start = value[BYTE_W-1:0];
            cbl_pkg::REG_END:   cfg_end   = value[BYTE_W-1:0];
            cbl_pkg::REG_ACK:   cfg_ack   = value[BYTE_W-1:0];
            cbl_pkg::REG_NACK:  cfg_nack  = value[BYTE_W-1:0];
            default:            cfg_base  = value[BASE_W-1:0];
        endcase
    end
    endtask

    task automatic load_settings(input logic [BYTE_W-1:0] start_c,
                                 input logic [BYTE_W-1:0] end_c,
                                 input logic [BYTE_W-1:0] ack_c,
                                 input logic [BYTE_W-1:0] nack_c,
                                 input logic [BASE_W-1:0] base);
    begin
        close_session();
        wait_drained();
        write_reg(cbl_pkg::REG_START, PDATA_W'(start_c));
        write_reg(cbl_pkg::REG_END, PDATA_W'(end_c));
        write_reg(cbl_pkg::REG_ACK, PDATA_W'(ack_c));
        write_reg(cbl_pkg::REG_NACK, PDATA_W'(nack_c));
        write_reg(cbl_pkg::REG_BASE, PDATA_W'(base));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    end
    endtask

    // one random session: mostly well formed, sometimes noise or broken
    task automatic run_session();
        int n_blocks;
        int k;
        int i;
        int r;
        logic [BYTE_W-1:0] len_byte;
        logic [BYTE_W-1:0] d;
        logic [BYTE_W-1:0] sum;
    begin
        close_session();
        if ($urandom_range(99) < 15)
        begin
            repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(255)));
        end
        else
        begin
            send_byte(cfg_start);
            n_blocks = $urandom_range(1, 3);
            for (k = 0; k < n_blocks && model_phase == cbl_pkg::PH_LENGTH; k++)
            begin
                r = $urandom_range(99);
                if (r < 5)
                    len_byte = BYTE_W'($urandom_range(BUFFER_BYTES + 1, 255));
                else if (r < 15)
                    len_byte = BYTE_W'($urandom_range(11, BUFFER_BYTES));
                else
                    len_byte = BYTE_W'($urandom_range(0, 10));
                send_byte(len_byte);
                if (model_phase == cbl_pkg::PH_DATA)
                begin
                    sum = '0;
                    for (i = 0; i < model_len - 1; i++)
                    begin
                        d = BYTE_W'($urandom_range(255));
                        sum = sum + d;
                        send_byte(d);
                    end
                    d = ~sum;
                    // corrupt the checksum now and then
                    if ($urandom_range(99) < 12)
                        d = d ^ BYTE_W'($urandom_range(1, 255));
                    send_byte(d);
                end
            end
            if (model_phase == cbl_pkg::PH_LENGTH && $urandom_range(99) < 75)
                send_byte(cfg_end);
        end
    end
    endtask

    // field extremes, every reply kind, zero and oversize lengths, address wrap
    task automatic test_directed();
    begin
        load_settings(8'hA5, 8'h5A, 8'h06, 8'h15, 24'hFFFFFE);
        // ignored while idle
        send_byte(8'h00);
        send_byte(8'hFF);
        // zero length, checksum only
        send_byte(8'hA5);
        send_byte(8'h00);
        send_byte(8'hFF);
        // writes across the top of the address space
        send_byte(8'h03);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'h80);
        send_byte(8'h7F);
        // length just over the buffer
        send_byte(8'h41);
        // bad checksum on a one-byte block
        send_byte(8'hA5);
        send_byte(8'h01);
        send_byte(8'h00);
        // end of image
        send_byte(8'hA5);
        send_byte(8'h5A);
        // largest length byte
        send_byte(8'hA5);
        send_byte(8'hFF);
        wait_drained();
    end
    endtask

    // full-size block with no idling on either side
    task automatic test_long_blocks();
        int i;
        logic [BYTE_W-1:0] d;
        logic [BYTE_W-1:0] sum;
    begin
        quiet <= 1'b1;
        load_settings(8'hFF, 8'h00, 8'hFF, 8'h00, 24'hFFFFFF);
        send_byte(8'hFF);
        send_byte(BYTE_W'(BUFFER_BYTES));
        sum = '0;
        for (i = 0; i < BUFFER_BYTES - 1; i++)
        begin
            d = BYTE_W'($urandom_range(255));
            sum = sum + d;
            send_byte(d);
        end
        send_byte(~sum);
        send_byte(8'h00);
        wait_drained();
        quiet <= 1'b0;
    end
    endtask

    // random sessions under several register settings
    task automatic test_random_sessions();
        int p;
        int goal;
        logic held;
    begin
        held = 1'b0;
        for (p = 0; p < 3; p++)
        begin
            case (p)
                0: load_settings('0, '0, '0, '0, '0);
                1: load_settings(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                                 BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                                 BASE_W'($urandom_range(24'hFFFFFF)));
                default: load_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF);
            endcase
            goal = sent_items + 16;
            while (sent_items < goal)
            begin
                run_session();
                // sender hold-off until the loader has caught up
                if (!held || $urandom_range(99) < 10)
                begin
                    wait_drained();
                    held = 1'b1;
                end
            end
        end
    end
    endtask

    // reset, tests in turn, final verdict
    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        rx_byte         = '0;
        out_stall       = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        quiet           = 1'b0;
        errors          = 0;
        sent_items      = 0;
        cycle_count     = 0;
        cfg_start       = '0;
        cfg_end         = '0;
        cfg_ack         = '0;
        cfg_nack        = '0;
        cfg_base        = '0;
        model_phase     = cbl_pkg::PH_IDLE;
        model_len       = 0;
        model_count     = 0;
        model_sum       = '0;
        model_next_addr = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_long_blocks();
        test_random_sessions();

        wait_drained();
        if (errors == 0 && loader_results_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
